FILE: sv/irht_pkg.sv
// ----------------------------------------------------------------------------
// irht_pkg
// Shared constants, codes and storage word layouts of the hash table core.
// ----------------------------------------------------------------------------
`default_nettype none

package irht_pkg;

  localparam int NODES           = 1024;
  localparam int MAX_BUCKETS     = 1024;
  localparam int INITIAL_BUCKETS = 4;

  localparam int NW   = $clog2(NODES);
  localparam int BW   = $clog2(MAX_BUCKETS);
  localparam int CNTW = $clog2(NODES + 1);
  localparam int CW   = (NW > BW) ? NW : BW;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  localparam logic REG_REHASH_BATCH = 1'b0;
  localparam logic REG_MAX_LOAD     = 1'b1;

  localparam logic [10:0] REHASH_BATCH_RESET = 11'd128;
  localparam logic [6:0]  MAX_LOAD_RESET     = 7'd8;

  typedef struct packed {
    logic          valid;
    logic [NW-1:0] handle;
  } link_t;

  typedef struct packed {
    logic        linked;
    link_t       next;
    logic [31:0] hash;
    logic [31:0] key;
  } node_t;

endpackage

`default_nettype wire

FILE: sv/irht_ram.sv
// ----------------------------------------------------------------------------
// irht_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module irht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/incremental_rehash_hash_table_core.sv
// ----------------------------------------------------------------------------
// incremental_rehash_hash_table_core
// Chained hash table with a newer and an older bucket array and incremental
// migration between them.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; each returns one word. An insert's time
// grows with every node migrated and every empty older bucket passed over; a
// lookup or delete takes the same migration time plus a node store read per
// chain node visited, and a further head read when the older array is searched
// as well; a delete that matches also clears the linked flag of the node.
// Starting a new, doubled bucket array clears it first, one bucket a cycle. A
// clear request, and the period after reset, sweep the node store one entry a
// cycle, so the block accepts no word during the sweep. All cycle costs come
// from the single read port of the bucket head store and of the node store.
`default_nettype none

module incremental_rehash_hash_table_core
  import irht_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    mode_i,
  input  wire logic [9:0]    node_handle_i,
  input  wire logic [31:0]   hash_code_i,
  input  wire logic [31:0]   key_value_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               found_o,
  output logic [9:0]         result_handle_o,
  output logic [10:0]        entry_count_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_INS_LINK, ST_INS_HEAD, ST_INS_GROW, ST_GROW_CLR,
    ST_MIG_CHK, ST_MIG_HEAD, ST_MIG_NODE, ST_MIG_PUSH,
    ST_SRCH_HEAD, ST_SRCH_NODE, ST_DEL_UNLINK, ST_DONE
  } state_e;

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [NW-1:0]   handle_q, handle_d;
  logic [31:0]     hash_q, hash_d, key_q, key_d;
  logic [BW-1:0]   newer_mask_q, newer_mask_d, older_mask_q, older_mask_d;
  logic            present_q, present_d, older_active_q, older_active_d;
  logic [CNTW-1:0] newer_count_q, newer_count_d, older_count_q, older_count_d;
  logic [BW-1:0]   pos_q, pos_d;
  logic [10:0]     done_q, done_d;
  logic            bank_q, bank_d;
  logic [CW-1:0]   clr_q, clr_d;
  logic            clear_req_q, clear_req_d;
  logic            tbl_old_q, tbl_old_d;
  logic            prev_head_q, prev_head_d;
  logic [NW-1:0]   cur_h_q, cur_h_d, prev_h_q, prev_h_d;
  node_t           cur_q, cur_d, prev_q, prev_d;
  logic            found_q, found_d;
  logic [NW-1:0]   res_h_q, res_h_d;
  logic            out_valid_q, out_valid_d;
  logic            out_found_q, out_found_d;
  logic [NW-1:0]   out_h_q, out_h_d;
  logic [10:0]     out_count_q, out_count_d;
  logic [10:0]     rehash_batch_q;
  logic [6:0]      max_load_q;

  logic            head_we, head_re;
  logic [BW:0]     head_waddr, head_raddr;
  link_t           head_wdata, head_rd;
  logic            node_we, node_re;
  logic [NW-1:0]   node_waddr, node_raddr;
  node_t           node_wdata, node_rd;

  logic [BW-1:0]   nb, ob, tb;
  logic [CNTW-1:0] size_w;
  logic [CNTW+6:0] thr_w;
  logic            mig_go, match_w, cfg_we;
  node_t           tmp_w;

  assign nb     = hash_q[BW-1:0] & newer_mask_q;
  assign ob     = hash_q[BW-1:0] & older_mask_q;
  assign tb     = tbl_old_q ? ob : nb;
  assign size_w = CNTW'(newer_mask_q) + CNTW'(1);
  assign thr_w  = (CNTW+7)'(size_w) * (CNTW+7)'(max_load_q);
  assign mig_go = older_active_q && (done_q < rehash_batch_q) &&
                  (older_count_q != '0) && (pos_q <= older_mask_q);
  assign match_w = (node_rd.hash == hash_q) && (node_rd.key == key_q);

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign result_handle_o = out_h_q;
  assign entry_count_o   = out_count_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MAX_LOAD) ? {25'd0, max_load_q} : {21'd0, rehash_batch_q};

  always_comb begin
    state_d        = state_q;
    mode_d         = mode_q;
    handle_d       = handle_q;
    hash_d         = hash_q;
    key_d          = key_q;
    newer_mask_d   = newer_mask_q;
    older_mask_d   = older_mask_q;
    present_d      = present_q;
    older_active_d = older_active_q;
    newer_count_d  = newer_count_q;
    older_count_d  = older_count_q;
    pos_d          = pos_q;
    done_d         = done_q;
    bank_d         = bank_q;
    clr_d          = clr_q;
    clear_req_d    = clear_req_q;
    tbl_old_d      = tbl_old_q;
    prev_head_d    = prev_head_q;
    cur_h_d        = cur_h_q;
    prev_h_d       = prev_h_q;
    cur_d          = cur_q;
    prev_d         = prev_q;
    found_d        = found_q;
    res_h_d        = res_h_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_found_d    = out_found_q;
    out_h_d        = out_h_q;
    out_count_d    = out_count_q;
    head_we        = 1'b0;
    head_waddr     = '0;
    head_wdata     = '0;
    head_re        = 1'b0;
    head_raddr     = '0;
    node_we        = 1'b0;
    node_waddr     = '0;
    node_wdata     = '0;
    node_re        = 1'b0;
    node_raddr     = '0;
    tmp_w          = node_rd;

    case (state_q)
      ST_SWEEP: begin
        node_we    = 1'b1;
        node_waddr = NW'(clr_q);
        if (clr_q < CW'(INITIAL_BUCKETS)) begin
          head_we    = 1'b1;
          head_waddr = {bank_q, BW'(clr_q)};
        end
        clr_d = clr_q + CW'(1);
        if (NW'(clr_q) == NW'(NODES - 1)) begin
          state_d = clear_req_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d      = mode_e'(mode_i);
          handle_d    = node_handle_i;
          hash_d      = hash_code_i;
          key_d       = key_value_i;
          done_d      = '0;
          tbl_old_d   = 1'b0;
          prev_head_d = 1'b1;
          found_d     = 1'b0;
          res_h_d     = '0;
          case (mode_e'(mode_i))
            MODE_INSERT: begin
              node_re    = 1'b1;
              node_raddr = node_handle_i;
              state_d    = ST_INS_LINK;
            end
            MODE_LOOKUP, MODE_DELETE: state_d = ST_MIG_CHK;
            default: begin
              newer_mask_d   = BW'(INITIAL_BUCKETS - 1);
              older_mask_d   = '0;
              present_d      = 1'b0;
              older_active_d = 1'b0;
              newer_count_d  = '0;
              older_count_d  = '0;
              pos_d          = '0;
              clr_d          = '0;
              clear_req_d    = 1'b1;
              state_d        = ST_SWEEP;
            end
          endcase
        end
      end
      ST_INS_LINK: begin
        if (node_rd.linked) begin
          state_d = ST_DONE;
        end else begin
          present_d    = 1'b1;
          newer_mask_d = present_q ? newer_mask_q : BW'(INITIAL_BUCKETS - 1);
          head_re      = 1'b1;
          head_raddr   = {bank_q, hash_q[BW-1:0] & newer_mask_d};
          state_d      = ST_INS_HEAD;
        end
      end
      ST_INS_HEAD: begin
        node_we           = 1'b1;
        node_waddr        = handle_q;
        node_wdata.linked = 1'b1;
        node_wdata.next   = head_rd;
        node_wdata.hash   = hash_q;
        node_wdata.key    = key_q;
        head_we           = 1'b1;
        head_waddr        = {bank_q, nb};
        head_wdata.valid  = 1'b1;
        head_wdata.handle = handle_q;
        newer_count_d     = newer_count_q + CNTW'(1);
        state_d           = ST_INS_GROW;
      end
      ST_INS_GROW: begin
        if (!older_active_q && ((CNTW+7)'(newer_count_q) >= thr_w) &&
            (newer_mask_q <= BW'(MAX_BUCKETS / 2 - 1))) begin
          // The current array becomes the older one by swapping banks.
          bank_d         = !bank_q;
          older_mask_d   = newer_mask_q;
          older_count_d  = newer_count_q;
          older_active_d = 1'b1;
          newer_mask_d   = {newer_mask_q[BW-2:0], 1'b1};
          newer_count_d  = '0;
          pos_d          = '0;
          clr_d          = '0;
          state_d        = ST_GROW_CLR;
        end else begin
          state_d = ST_MIG_CHK;
        end
      end
      ST_GROW_CLR: begin
        head_we    = 1'b1;
        head_waddr = {bank_q, BW'(clr_q)};
        clr_d      = clr_q + CW'(1);
        if (BW'(clr_q) == newer_mask_q) begin
          state_d = ST_MIG_CHK;
        end
      end
      ST_MIG_CHK: begin
        if (mig_go) begin
          head_re    = 1'b1;
          head_raddr = {!bank_q, pos_q};
          state_d    = ST_MIG_HEAD;
        end else begin
          if (older_active_q && (older_count_q == '0)) begin
            older_active_d = 1'b0;
            older_mask_d   = '0;
          end
          if (mode_q == MODE_INSERT) begin
            state_d = ST_DONE;
          end else begin
            head_re    = 1'b1;
            head_raddr = {bank_q, nb};
            state_d    = ST_SRCH_HEAD;
          end
        end
      end
      ST_MIG_HEAD: begin
        if (!head_rd.valid) begin
          pos_d   = pos_q + BW'(1);
          state_d = ST_MIG_CHK;
        end else begin
          cur_h_d    = head_rd.handle;
          node_re    = 1'b1;
          node_raddr = head_rd.handle;
          state_d    = ST_MIG_NODE;
        end
      end
      ST_MIG_NODE: begin
        cur_d         = node_rd;
        head_we       = 1'b1;
        head_waddr    = {!bank_q, pos_q};
        head_wdata    = node_rd.next;
        older_count_d = older_count_q - CNTW'(1);
        head_re       = 1'b1;
        head_raddr    = {bank_q, node_rd.hash[BW-1:0] & newer_mask_q};
        state_d       = ST_MIG_PUSH;
      end
      ST_MIG_PUSH: begin
        node_we           = 1'b1;
        node_waddr        = cur_h_q;
        node_wdata        = cur_q;
        node_wdata.next   = head_rd;
        head_we           = 1'b1;
        head_waddr        = {bank_q, cur_q.hash[BW-1:0] & newer_mask_q};
        head_wdata.valid  = 1'b1;
        head_wdata.handle = cur_h_q;
        newer_count_d     = newer_count_q + CNTW'(1);
        done_d            = done_q + 11'd1;
        state_d           = ST_MIG_CHK;
      end
      ST_SRCH_HEAD: begin
        if (head_rd.valid) begin
          cur_h_d    = head_rd.handle;
          node_re    = 1'b1;
          node_raddr = head_rd.handle;
          state_d    = ST_SRCH_NODE;
        end else if (!tbl_old_q && older_active_q) begin
          tbl_old_d   = 1'b1;
          prev_head_d = 1'b1;
          head_re     = 1'b1;
          head_raddr  = {!bank_q, ob};
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SRCH_NODE: begin
        if (match_w) begin
          found_d = 1'b1;
          res_h_d = cur_h_q;
          if (mode_q == MODE_DELETE) begin
            // Unlink from whatever points at the match, head or node.
            if (prev_head_q) begin
              head_we    = 1'b1;
              head_waddr = {bank_q ^ tbl_old_q, tb};
              head_wdata = node_rd.next;
            end else begin
              node_we         = 1'b1;
              node_waddr      = prev_h_q;
              node_wdata      = prev_q;
              node_wdata.next = node_rd.next;
            end
            if (tbl_old_q) begin
              older_count_d = older_count_q - CNTW'(1);
            end else begin
              newer_count_d = newer_count_q - CNTW'(1);
            end
            cur_d   = node_rd;
            state_d = ST_DEL_UNLINK;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          prev_head_d = 1'b0;
          prev_h_d    = cur_h_q;
          prev_d      = node_rd;
          if (node_rd.next.valid) begin
            cur_h_d    = node_rd.next.handle;
            node_re    = 1'b1;
            node_raddr = node_rd.next.handle;
          end else if (!tbl_old_q && older_active_q) begin
            tbl_old_d   = 1'b1;
            prev_head_d = 1'b1;
            head_re     = 1'b1;
            head_raddr  = {!bank_q, ob};
            state_d     = ST_SRCH_HEAD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DEL_UNLINK: begin
        tmp_w        = cur_q;
        tmp_w.linked = 1'b0;
        node_we      = 1'b1;
        node_waddr   = cur_h_q;
        node_wdata   = tmp_w;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_h_d     = res_h_q;
          out_count_d = 11'(newer_count_q + older_count_q);
          clear_req_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_SWEEP;
      newer_mask_q   <= BW'(INITIAL_BUCKETS - 1);
      older_mask_q   <= '0;
      present_q      <= 1'b0;
      older_active_q <= 1'b0;
      newer_count_q  <= '0;
      older_count_q  <= '0;
      pos_q          <= '0;
      done_q         <= '0;
      bank_q         <= 1'b0;
      clr_q          <= '0;
      clear_req_q    <= 1'b0;
      out_valid_q    <= 1'b0;
      rehash_batch_q <= REHASH_BATCH_RESET;
      max_load_q     <= MAX_LOAD_RESET;
    end else begin
      state_q        <= state_d;
      newer_mask_q   <= newer_mask_d;
      older_mask_q   <= older_mask_d;
      present_q      <= present_d;
      older_active_q <= older_active_d;
      newer_count_q  <= newer_count_d;
      older_count_q  <= older_count_d;
      pos_q          <= pos_d;
      done_q         <= done_d;
      bank_q         <= bank_d;
      clr_q          <= clr_d;
      clear_req_q    <= clear_req_d;
      out_valid_q    <= out_valid_d;
      if (cfg_we) begin
        if (paddr[2] == REG_MAX_LOAD) begin
          max_load_q <= pwdata[6:0];
        end else begin
          rehash_batch_q <= pwdata[10:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    handle_q    <= handle_d;
    hash_q      <= hash_d;
    key_q       <= key_d;
    tbl_old_q   <= tbl_old_d;
    prev_head_q <= prev_head_d;
    cur_h_q     <= cur_h_d;
    prev_h_q    <= prev_h_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    found_q     <= found_d;
    res_h_q     <= res_h_d;
    out_found_q <= out_found_d;
    out_h_q     <= out_h_d;
    out_count_q <= out_count_d;
  end

  // Both bucket arrays share one store; the top address bit selects the bank.
  irht_ram #(
    .WIDTH($bits(link_t)),
    .DEPTH(2 * MAX_BUCKETS)
  ) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(head_waddr),
    .wdata_i(head_wdata),
    .re_i   (head_re),
    .raddr_i(head_raddr),
    .rdata_o(head_rd)
  );

  irht_ram #(
    .WIDTH($bits(node_t)),
    .DEPTH(NODES)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(node_waddr),
    .wdata_i(node_wdata),
    .re_i   (node_re),
    .raddr_i(node_raddr),
    .rdata_o(node_rd)
  );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for incremental_rehash_hash_table_core. A behavioural
// copy of the chained table predicts every result word. Directed and random
// requests run under several rehash settings, with random stalls and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import irht_pkg::*;

  localparam int LIMIT = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = MODE_LOOKUP;
  logic [9:0]  node_handle_i = '0;
  logic [31:0] hash_code_i = '0;
  logic [31:0] key_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        found_o;
  logic [9:0]  result_handle_o;
  logic [10:0] entry_count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  incremental_rehash_hash_table_core dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct {
    logic        found;
    logic [9:0]  handle;
    logic [10:0] count;
  } answer_t;

  answer_t answers_due[$];

  // Behavioural copy of the table.
  logic [10:0] tbl_new[MAX_BUCKETS];
  logic [10:0] tbl_old[MAX_BUCKETS/2];
  logic [10:0] tbl_next[NODES];
  logic [31:0] tbl_hash[NODES];
  logic [31:0] tbl_key[NODES];
  bit          tbl_linked[NODES];
  int          new_mask, old_mask, new_cnt, old_cnt, mig_pos;
  bit          new_up, old_up;
  int          cfg_batch = 128, cfg_load = 8;

  int  cycles = 0, errors = 0, words_sent = 0, words_checked = 0, clears = 0;
  int  hold_left = 0, stall_left = 0;
  bit  no_idle = 1'b0;

  function automatic void tbl_clear();
    foreach (tbl_new[i]) tbl_new[i] = '0;
    foreach (tbl_old[i]) tbl_old[i] = '0;
    foreach (tbl_linked[i]) tbl_linked[i] = 1'b0;
    new_mask = INITIAL_BUCKETS - 1;
    old_mask = 0;
    new_up = 1'b0;
    old_up = 1'b0;
    new_cnt = 0;
    old_cnt = 0;
    mig_pos = 0;
  endfunction

  function automatic void push_new(input int h);
    int b;
    b = tbl_hash[h] & new_mask;
    tbl_next[h] = tbl_new[b];
    tbl_new[b] = {1'b1, h[9:0]};
    new_cnt++;
  endfunction

  function automatic void migrate_batch();
    int done;
    logic [10:0] head;
    done = 0;
    while (old_up && done < cfg_batch && old_cnt > 0 && mig_pos <= old_mask &&
           mig_pos < MAX_BUCKETS/2) begin
      head = tbl_old[mig_pos];
      if (!head[10]) begin
        mig_pos++;
      end else begin
        tbl_old[mig_pos] = tbl_next[head[9:0]];
        old_cnt--;
        push_new(int'(head[9:0]));
        done++;
      end
    end
    if (old_up && old_cnt == 0) begin
      foreach (tbl_old[i]) tbl_old[i] = '0;
      old_up = 1'b0;
      old_mask = 0;
    end
  endfunction

  function automatic void start_double();
    int size;
    size = new_mask + 1;
    foreach (tbl_old[i]) tbl_old[i] = (i < size) ? tbl_new[i] : 11'd0;
    old_mask = new_mask;
    old_cnt = new_cnt;
    old_up = 1'b1;
    foreach (tbl_new[i]) tbl_new[i] = '0;
    new_mask = size * 2 - 1;
    new_cnt = 0;
    mig_pos = 0;
  endfunction

  // Walks one chain; prev is -1 when the match sits at the bucket head.
  function automatic void walk_chain(input bit in_new, input logic [31:0] hash,
                                     input logic [31:0] key,
                                     output bit hit, output int prev, output int h);
    logic [10:0] link;
    int steps;
    link = in_new ? tbl_new[hash & new_mask] : tbl_old[hash & old_mask];
    prev = -1;
    steps = 0;
    hit = 1'b0;
    h = 0;
    while (link[10] && steps < NODES && !hit) begin
      h = int'(link[9:0]);
      if (tbl_hash[h] == hash && tbl_key[h] == key) begin
        hit = 1'b1;
      end else begin
        prev = h;
        link = tbl_next[h];
        steps++;
      end
    end
  endfunction

  function automatic void find_entry(input logic [31:0] hash, input logic [31:0] key,
                                     input bit remove, output bit hit, output int h);
    int prev;
    bit in_new;
    walk_chain(1'b1, hash, key, hit, prev, h);
    in_new = hit;
    if (!hit && old_up) walk_chain(1'b0, hash, key, hit, prev, h);
    if (hit && remove) begin
      if (prev >= 0) tbl_next[prev] = tbl_next[h];
      else if (in_new) tbl_new[hash & new_mask] = tbl_next[h];
      else tbl_old[hash & old_mask] = tbl_next[h];
      tbl_linked[h] = 1'b0;
      if (in_new) new_cnt--;
      else old_cnt--;
    end
  endfunction

  function automatic answer_t predict_answer(input logic [1:0] mode, input int h,
                                             input logic [31:0] hash,
                                             input logic [31:0] key);
    answer_t a;
    bit hit;
    int hh;
    int size;
    hit = 1'b0;
    hh = 0;
    case (mode)
      MODE_INSERT: begin
        if (!tbl_linked[h]) begin
          if (!new_up) begin
            new_up = 1'b1;
            new_mask = INITIAL_BUCKETS - 1;
          end
          tbl_hash[h] = hash;
          tbl_key[h] = key;
          tbl_linked[h] = 1'b1;
          push_new(h);
          if (!old_up) begin
            size = new_mask + 1;
            if (new_cnt >= size * cfg_load && size * 2 <= MAX_BUCKETS) start_double();
          end
          migrate_batch();
        end
      end
      MODE_LOOKUP: begin
        migrate_batch();
        find_entry(hash, key, 1'b0, hit, hh);
      end
      MODE_DELETE: begin
        migrate_batch();
        find_entry(hash, key, 1'b1, hit, hh);
      end
      default: tbl_clear();
    endcase
    a.found = hit;
    a.handle = hit ? hh[9:0] : 10'd0;
    a.count = 11'(new_cnt + old_cnt);
    return a;
  endfunction

  task automatic send_word(input logic [1:0] mode, input logic [9:0] h,
                           input logic [31:0] hash, input logic [31:0] key);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    mode_i <= mode;
    node_handle_i <= h;
    hash_code_i <= hash;
    key_value_i <= key;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    answers_due.push_back(predict_answer(mode, int'(h), hash, key));
    words_sent++;
    if (mode == MODE_CLEAR) clears++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic regsel, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (regsel == REG_REHASH_BATCH) cfg_batch = value & 'h7FF;
    else cfg_load = value & 'h7F;
  endtask

  task automatic set_rehash(input int batch, input int load);
    drain();
    write_reg(REG_REHASH_BATCH, batch);
    write_reg(REG_MAX_LOAD, load);
  endtask

  // One request drawn mostly from live entries, so that hits and deletes are common.
  task automatic random_word(input int key_span);
    int pick, h, tries;
    logic [31:0] hash, key;
    pick = $urandom_range(0, 99);
    hash = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom;
    key = (key_span > 0) ? $urandom_range(0, key_span) : $urandom;
    h = $urandom_range(0, NODES - 1);
    if (pick < 1) begin
      send_word(MODE_CLEAR, 10'($urandom), $urandom, $urandom);
    end else if (pick < 50) begin
      tries = 0;
      while (tbl_linked[h] && tries < 8) begin
        h = $urandom_range(0, NODES - 1);
        tries++;
      end
      send_word(MODE_INSERT, h[9:0], hash, key);
    end else begin
      tries = 0;
      while (!tbl_linked[h] && tries < 16) begin
        h = $urandom_range(0, NODES - 1);
        tries++;
      end
      if (tbl_linked[h] && $urandom_range(0, 3) != 0) begin
        hash = tbl_hash[h];
        key = tbl_key[h];
      end
      send_word(pick < 75 ? MODE_LOOKUP : MODE_DELETE, 10'($urandom), hash, key);
    end
  endtask

  task automatic test_directed();
    send_word(MODE_LOOKUP, 10'd0, 32'd0, 32'd0);
    send_word(MODE_DELETE, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 10'd0, 32'd0, 32'd0);
    send_word(MODE_INSERT, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 10'h3FF, 32'h1234_5678, 32'h5555_AAAA);
    send_word(MODE_INSERT, 10'h155, 32'hAAAA_5555, 32'h5555_AAAA);
    send_word(MODE_INSERT, 10'h2AA, 32'hAAAA_5555, 32'h5555_AAAA);
    send_word(MODE_LOOKUP, 10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_LOOKUP, 10'd0, 32'hAAAA_5555, 32'h5555_AAAA);
    send_word(MODE_LOOKUP, 10'd0, 32'hAAAA_5555, 32'h5555_AAAB);
    send_word(MODE_DELETE, 10'd0, 32'hAAAA_5555, 32'h5555_AAAA);
    send_word(MODE_DELETE, 10'd0, 32'hAAAA_5555, 32'h5555_AAAA);
    send_word(MODE_DELETE, 10'd0, 32'hAAAA_5555, 32'h5555_AAAA);
    send_word(MODE_DELETE, 10'd0, 32'd0, 32'd0);
    send_word(MODE_CLEAR, 10'd0, 32'd0, 32'd0);
    send_word(MODE_LOOKUP, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Zero load doubles on every insert up to the bucket limit; zero batch then
  // allows no migration.
  task automatic test_zero_settings();
    set_rehash(1024, 0);
    repeat (12) send_word(MODE_INSERT, 10'($urandom), $urandom, $urandom);
    set_rehash(0, 1);
    repeat (6) random_word(0);
    send_word(MODE_CLEAR, 10'd0, 32'd0, 32'd0);
  endtask

  task automatic test_random_phase(input int batch, input int load, input int n,
                                   input int key_span);
    set_rehash(batch, load);
    repeat (n) random_word(key_span);
  endtask

  task automatic test_output_hold();
    drain();
    hold_left = 600;
    repeat (40) random_word(0);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("incremental_rehash_hash_table_core test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || no_idle) begin
      out_ready_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        want = answers_due.pop_front();
        words_checked++;
        if (found_o !== want.found || result_handle_o !== want.handle ||
            entry_count_o !== want.count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch word %0d: want found %0b handle %0d count %0d, got %0b %0d %0d",
                     words_checked, want.found, want.handle, want.count,
                     found_o, result_handle_o, entry_count_o);
        end
      end
    end
  end

  initial begin
    tbl_clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_settings();
    test_random_phase(1, 1, 400, 0);
    test_random_phase(1024, 64, 350, 15);
    test_output_hold();
    test_random_phase(3, 2, 400, 0);
    no_idle = 1'b1;
    test_random_phase(128, 8, 450, 255);
    drain();
    if (answers_due.size() != 0) errors++;
    $display("Sent %0d request words (%0d clears), checked %0d results.",
             words_sent, clears, words_checked);
    $display("Covered rehash batches 0 to 1024, loads 0 to 64 and a long output hold-off.");
    if (errors == 0) begin
      $display("incremental_rehash_hash_table_core test passed");
    end else begin
      $display("incremental_rehash_hash_table_core test failed");
    end
    $finish;
  end

endmodule
